[rtl/rrd_pkg.sv]
package rrd_pkg;

  localparam int unsigned KeyW        = 64;
  localparam int unsigned LenW        = 16;
  localparam int unsigned CntW        = 4;
  localparam int unsigned TableDefault = 64;

  localparam logic [CntW-1:0] CntMax = 4'hF;
  localparam logic [CntW-1:0] CntOne = 4'd1;

  // APB register map: one 32-bit register per word
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-3:0] RegReplicaCount = 1'b0;

  localparam logic [CntW-1:0] ReplicaReset = 4'd1;

  typedef struct packed {
    logic hit;        // key is tracked
    logic free_avail; // at least one entry is free
  } rrd_lookup_t;

endpackage

[rtl/rrd_table.sv]
module rrd_table #(
  parameter int unsigned TABLE_ENTRIES = rrd_pkg::TableDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rrd_pkg::KeyW-1:0] key_i,
  input  logic [rrd_pkg::CntW-1:0] need_i,
  input  logic                     upd_i,
  output rrd_pkg::rrd_lookup_t     lookup_o
);
  import rrd_pkg::*;

  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] cnt_zero;
  logic [TABLE_ENTRIES-1:0] hit_oh;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic                     hit;
  logic                     track;

  // isolate lowest set bit: lowest index wins for both match and free slot
  assign hit_oh  = match_vec & (~match_vec + TABLE_ENTRIES'(1));
  assign free_oh = ~valid_vec & (valid_vec + TABLE_ENTRIES'(1));
  assign hit     = |match_vec;
  assign track   = (need_i > CntOne);

  assign lookup_o.hit        = hit;
  assign lookup_o.free_avail = ~&valid_vec;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : gen_entry
    logic            valid_q;
    logic [CntW-1:0] count_q;
    logic [KeyW-1:0] key_q;
    logic [CntW-1:0] inc;

    assign inc          = (count_q == CntMax) ? CntMax : count_q + CntOne;
    assign valid_vec[k] = valid_q;
    assign match_vec[k] = valid_q && (key_q == key_i);
    assign cnt_zero[k]  = (count_q == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
        count_q <= '0;
      end else if (upd_i) begin
        if (hit_oh[k]) begin
          if (inc >= need_i) begin
            valid_q <= 1'b0;
            count_q <= '0;
          end else begin
            count_q <= inc;
          end
        end else if (!hit && track && free_oh[k]) begin
          valid_q <= 1'b1;
          count_q <= CntOne;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (upd_i && !hit && track && free_oh[k]) begin
        key_q <= key_i;
      end
    end
  end

`ifndef SYNTH
  // a tracked entry always holds at least one arrival
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_vec & cnt_zero) == '0)
    else $error("valid entry with zero count");

  // a new key is never placed while the same key is already tracked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(match_vec) <= 1)
    else $error("key tracked in more than one entry");

  // inserting a tracked key grows the table by exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && !hit && track && lookup_o.free_avail) |=>
      $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not occupy one entry");
`endif

endmodule

[rtl/replica_response_deduplicator.sv]
// Path: an accepted beat is held in the input stage register, and its result is then
// loaded into the result register, from which the result beat is taken.
// Throughput: one beat per cycle while m_axis_tready is high; the key match over the whole
// table is done in parallel, and the table update lands at the edge that loads the result.
// Reset (rst_ni, asynchronous, active low): table emptied at once, replica_count = 1,
// both pipeline registers empty. Stored keys are not cleared and need no clearing pass.
module replica_response_deduplicator #(
  parameter int unsigned TABLE_ENTRIES = rrd_pkg::TableDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beats
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [79:0]                  s_axis_tdata,  // [63:0] clock_key, [79:64] payload_length
  // result beats
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // [15:0] forward_size
  output logic [1:0]                   m_axis_tuser,  // [0] forward, [1] table_full
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrd_pkg::ApbAddrW-1:0] paddr,
  input  logic [rrd_pkg::ApbDataW-1:0] pwdata,
  output logic [rrd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import rrd_pkg::*;

  // configuration register
  logic [CntW-1:0] rc_q;
  logic            reg_sel;
  logic [CntW-1:0] need;

  // input stage
  logic            s1_valid_q;
  logic [KeyW-1:0] s1_key_q;
  logic [LenW-1:0] s1_len_q;
  logic            s1_adv;

  // result stage
  logic            out_valid_q;
  logic            out_fwd_q;
  logic            out_full_q;
  logic [LenW-1:0] out_size_q;

  rrd_lookup_t     lk;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1:2] == RegReplicaCount);
  assign prdata  = reg_sel ? {{(ApbDataW-CntW){1'b0}}, rc_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= ReplicaReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      rc_q <= pwdata[CntW-1:0];
    end
  end

  // zero replicas behaves as one: nothing gets tracked
  assign need = (rc_q == '0) ? CntOne : rc_q;

  // Advance the input stage whenever the result register is free or being drained.
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_key_q <= s_axis_tdata[KeyW-1:0];
      s1_len_q <= s_axis_tdata[KeyW+LenW-1:KeyW];
    end
  end

  // Look up the key and update the table in the same cycle, so the next beat
  // sees the new table contents.
  rrd_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (s1_key_q),
    .need_i  (need),
    .upd_i   (s1_adv),
    .lookup_o(lk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Drop duplicates: a hit gives an all-zero result.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_fwd_q  <= !lk.hit && (s1_len_q != '0);
      out_size_q <= lk.hit ? '0 : s1_len_q;
      out_full_q <= !lk.hit && (need > CntOne) && !lk.free_avail;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_size_q;
  assign m_axis_tuser  = {out_full_q, out_fwd_q};

`ifndef SYNTH
  // a duplicate always yields an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && lk.hit) |=> (out_valid_q && !out_fwd_q && !out_full_q && out_size_q == '0))
    else $error("duplicate not dropped");

  // a stalled input stage keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_key_q) && $stable(s1_len_q)))
    else $error("input stage lost a beat");

  // table_full only flags when tracking is required
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && need <= CntOne) |=> !out_full_q)
    else $error("table_full raised without tracking");
`endif

endmodule

[tb/replica_response_deduplicator_test.sv]
`timescale 1ns / 100ps

module replica_response_deduplicator_test;
  import rrd_pkg::*;

  // One result beat as the block reports it
  typedef struct packed {
    logic            forward;
    logic [LenW-1:0] size;
    logic            full;
  } verdict_t;

  // Directed stimulus: either a response beat or a register write
  typedef enum logic [1:0] {
    RowBeat,
    RowReplicas,
    RowUnmapped
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [KeyW-1:0]     key;
    logic [LenW-1:0]     len;
    logic [ApbDataW-1:0] wdata;
    logic                typed;  // want holds the result to expect
    verdict_t            want;
  } stim_row_t;

  // One random phase: replica setting, beats to send, share of fresh keys (percent)
  typedef struct packed {
    logic [CntW-1:0] replicas;
    int unsigned     beats;
    int unsigned     fresh_pct;
  } phase_t;

  // Second register slot, outside the map: writes there must change nothing
  localparam logic [ApbAddrW-3:0] RegUnmapped = 1'b1;

  localparam verdict_t Dropped = '0;
  localparam logic [KeyW-1:0] KeyA = 64'h0123_4567_89AB_CDEF;
  localparam logic [KeyW-1:0] KeyB = 64'h8000_0000_0000_0001;
  localparam logic [KeyW-1:0] KeyC = 64'hFEDC_BA98_7654_3210;

  localparam int NumRows = 21;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // after reset one replica is expected, so nothing is ever tracked
    '{RowBeat,     64'h0,   16'h0000, 32'h0, 1'b1, Dropped},
    '{RowBeat,     '1,      16'hFFFF, 32'h0, 1'b1, '{1'b1, 16'hFFFF, 1'b0}},
    '{RowBeat,     64'h0,   16'h0001, 32'h0, 1'b1, '{1'b1, 16'h0001, 1'b0}},
    // three replicas: first copy passes, the next two are dropped and free the entry
    '{RowReplicas, 64'h0,   16'h0000, 32'h3, 1'b0, Dropped},
    '{RowBeat,     KeyA,    16'h0005, 32'h0, 1'b0, Dropped},
    '{RowBeat,     KeyA,    16'h0007, 32'h0, 1'b1, Dropped},
    '{RowBeat,     KeyB,    16'h0000, 32'h0, 1'b0, Dropped},
    '{RowBeat,     KeyA,    16'h0009, 32'h0, 1'b1, Dropped},
    '{RowBeat,     KeyA,    16'h0009, 32'h0, 1'b0, Dropped},
    '{RowBeat,     KeyB,    16'h0003, 32'h0, 1'b1, Dropped},
    // lower the setting while both keys are still tracked
    '{RowReplicas, 64'h0,   16'h0000, 32'h2, 1'b0, Dropped},
    '{RowBeat,     KeyB,    16'h0004, 32'h0, 1'b1, Dropped},
    '{RowBeat,     KeyA,    16'h0004, 32'h0, 1'b1, Dropped},
    '{RowBeat,     KeyB,    16'h0004, 32'h0, 1'b0, Dropped},
    // a zero setting behaves like one replica
    '{RowReplicas, 64'h0,   16'h0000, 32'h0, 1'b0, Dropped},
    '{RowBeat,     KeyB,    16'h0008, 32'h0, 1'b1, Dropped},
    '{RowBeat,     KeyC,    16'h0008, 32'h0, 1'b0, Dropped},
    '{RowBeat,     KeyC,    16'h0008, 32'h0, 1'b0, Dropped},
    '{RowUnmapped, 64'h0,   16'h0000, 32'hFFFF_FFFF, 1'b0, Dropped},
    '{RowBeat,     KeyC,    16'h8000, 32'h0, 1'b0, Dropped},
    '{RowReplicas, 64'h0,   16'h0000, 32'hF, 1'b0, Dropped}
  };

  // The two phases at fifteen replicas take enough fresh keys to fill the table
  localparam int NumPhases = 8;
  localparam phase_t Phases [NumPhases] = '{
    '{4'd2,  120, 35},
    '{4'd15, 200, 60},
    '{4'd4,  120, 30},
    '{4'd1,  100, 40},
    '{4'd0,  100, 40},
    '{4'd3,  120, 35},
    '{4'd15, 140, 70},
    '{4'd7,  100, 30}
  };

  localparam int PoolDepth    = 96;   // recent keys that duplicates are drawn from
  localparam int HoldAtBeat   = 250;  // random beat at which the receiver backs off
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 4;    // covers the input stage and the result register, plus margin
  localparam int IdleLimit    = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata;   // [63:0] clock_key, [79:64] payload_length
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [15:0] forward_size
  logic [1:0]          m_axis_tuser;   // [0] forward, [1] table_full
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  replica_response_deduplicator #(
    .TABLE_ENTRIES(TableDefault)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the duplicate table and of the replica setting
  logic [KeyW-1:0] shadow_key [TableDefault];
  logic [CntW-1:0] shadow_cnt [TableDefault];
  logic            shadow_vld [TableDefault];
  logic [CntW-1:0] replicas;

  verdict_t    pending_q [$];
  int unsigned errors;
  int unsigned beats_sent;
  int unsigned n_forward;
  int unsigned n_dropped;
  int unsigned n_full;
  bit          hold_rx;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the result of one response and update the shadow table
  function automatic verdict_t dedup_verdict(input logic [KeyW-1:0] key,
                                             input logic [LenW-1:0] len);
    verdict_t        v;
    int              hit;
    int              slot;
    logic [CntW-1:0] need;
    logic [CntW-1:0] c;
    v    = '0;
    hit  = -1;
    slot = -1;
    need = (replicas == '0) ? CntOne : replicas;
    for (int k = 0; k < TableDefault; k++) begin
      if (shadow_vld[k]) begin
        if (hit < 0 && shadow_key[k] == key) hit = k;
      end else if (slot < 0) begin
        slot = k;
      end
    end
    if (hit >= 0) begin
      // later copy: count it, saturate, free the entry once enough have come
      c = shadow_cnt[hit];
      if (c != CntMax) c = c + CntOne;
      shadow_cnt[hit] = c;
      if (c >= need) begin
        shadow_vld[hit] = 1'b0;
        shadow_cnt[hit] = '0;
      end
      return v;
    end
    v.forward = (len != '0);
    v.size    = len;
    if (need > CntOne) begin
      if (slot >= 0) begin
        shadow_key[slot] = key;
        shadow_cnt[slot] = CntOne;
        shadow_vld[slot] = 1'b1;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one
  function automatic int gap_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after it is taken.
  // tvalid stays high so that the next beat can follow without a gap.
  task automatic send_beat(input logic [KeyW-1:0] key, input logic [LenW-1:0] len,
                           input logic typed, input verdict_t want);
    int       gap;
    verdict_t pred;
    gap = gap_len((beats_sent % 100) < 20);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = dedup_verdict(key, len);
    pending_q.push_back(typed ? want : pred);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Drop tvalid and hold until every result is back, so the block is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Setup cycle, access cycle, then release the bus
  task automatic write_reg(input logic [ApbAddrW-3:0] idx, input logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegReplicaCount) replicas = data[CntW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random back-pressure with calm stretches, plus one long hold-off
  // requested by the sender so that the block fills and stalls its input.
  initial begin
    int rx_gap;
    int rx_cycle;
    rx_cycle = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      rx_gap = gap_len(((rx_cycle / 128) % 4) == 0);
      if (rx_gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (rx_gap - 1) @(negedge clk_i);
      end
    end
  end

  // Result checker: every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: forward_size %0h, tuser %b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tuser[0] !== want.forward) begin
          $error("forward: expected %0b, got %0b", want.forward, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata !== want.size) begin
          $error("forward_size: expected %0h, got %0h", want.size, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[1] !== want.full) begin
          $error("table_full: expected %0b, got %0b", want.full, m_axis_tuser[1]);
          errors++;
        end
        if (want.forward) n_forward++;
        else if (!want.full && want.size == '0) n_dropped++;
        if (want.full) n_full++;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no beat accepted for %0d cycles", IdleLimit);
    $display("replica_response_deduplicator_test: errors");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] key_pool [$];
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    int              r;
    int              random_beats;

    // drive every input to a known value before the first edge
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_rx       = 1'b0;
    errors        = 0;
    beats_sent    = 0;
    n_forward     = 0;
    n_dropped     = 0;
    n_full        = 0;
    random_beats  = 0;
    replicas      = ReplicaReset;
    for (int k = 0; k < TableDefault; k++) begin
      shadow_key[k] = '0;
      shadow_cnt[k] = '0;
      shadow_vld[k] = 1'b0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: reset setting, field extremes, lowering and zero settings
    for (int row = 0; row < NumRows; row++) begin
      case (DirectedRows[row].kind)
        RowBeat: begin
          send_beat(DirectedRows[row].key, DirectedRows[row].len,
                    DirectedRows[row].typed, DirectedRows[row].want);
        end
        RowReplicas: begin
          settle();
          write_reg(RegReplicaCount, DirectedRows[row].wdata);
        end
        default: begin
          settle();
          write_reg(RegUnmapped, DirectedRows[row].wdata);
        end
      endcase
    end

    // Random part: duplicates of recent keys mixed with fresh keys, one setting per phase
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(RegReplicaCount,
                ($urandom() & ~32'hF) | {{(ApbDataW-CntW){1'b0}}, Phases[p].replicas});
      for (int i = 0; i < Phases[p].beats; i++) begin
        if (random_beats == HoldAtBeat) hold_rx = 1'b1;
        if (key_pool.size() == 0 || $urandom_range(0, 99) < Phases[p].fresh_pct) begin
          r = $urandom_range(0, 19);
          if (r == 0) key = '0;
          else if (r == 1) key = '1;
          else key = {$urandom(), $urandom()};
          key_pool.push_back(key);
          if (key_pool.size() > PoolDepth) void'(key_pool.pop_front());
        end else begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < 20) len = '0;
        else if (r < 30) len = '1;
        else len = LenW'($urandom_range(0, 16'hFFFF));
        send_beat(key, len, 1'b0, Dropped);
        random_beats++;
      end
    end

    // Hold until everything is back, then allow the pipeline to empty
    settle();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      errors++;
    end

    $display("Sent %0d responses over replica settings 0, 1 and up to 15, with back-pressure",
             beats_sent);
    $display("Results: %0d forwarded, %0d held back (duplicates or empty payloads), %0d untracked on a full table",
             n_forward, n_dropped, n_full);
    if (errors == 0) begin
      $display("replica_response_deduplicator_test: clean");
    end else begin
      $display("replica_response_deduplicator_test: errors");
    end
    $finish;
  end

endmodule
